>>> design/ffpa_pkg.sv
// Shared widths, codes and item/result types of the first-fit partition allocator.
package ffpa_pkg;

	localparam int DEF_PARTITIONS = 8;
	localparam int DEF_SIZE_BITS  = 16;

	localparam int JOB_W     = 16;
	localparam int IDX_W     = 3;
	localparam int STATUS_W  = 3;
	localparam int WASTE_W   = 16;
	localparam int TOTAL_W   = 19;
	localparam int WSUM_W    = 20;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_WAIT         = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NEVER_FITS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

	typedef struct packed {
		logic             action;
		logic [JOB_W-1:0] job_size;
		logic [IDX_W-1:0] release_index;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    granted_index;
		logic [WASTE_W-1:0]  waste;
		logic [TOTAL_W-1:0]  internal_total;
		logic [TOTAL_W-1:0]  external_total;
	} result_t;

endpackage

>>> design/ffpa_step.sv
// Decision logic for one request: first-fit pick, release, waste and free-size totals.
module ffpa_step
	import ffpa_pkg::*;
#(
	parameter int PARTITIONS = DEF_PARTITIONS,
	parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
	input  item_t                                  item,
	input  logic [PARTITIONS-1:0][SIZE_BITS-1:0]   size,
	input  logic [PARTITIONS-1:0]                  busy,
	input  logic [PARTITIONS-1:0][SIZE_BITS-1:0]   held,
	input  logic [WSUM_W-1:0]                      waste_sum,
	output logic [PARTITIONS-1:0]                  busy_next,
	output logic [PARTITIONS-1:0][SIZE_BITS-1:0]   held_next,
	output logic [WSUM_W-1:0]                      waste_sum_next,
	output result_t                                result
);

	// Wide enough for the waste sum and one waste value plus a carry.
	localparam int WW = ((SIZE_BITS > WSUM_W) ? SIZE_BITS : WSUM_W) + 1;
	// Wide enough for the sum of all partition sizes.
	localparam int EW = ((SIZE_BITS + 3) > TOTAL_W) ? (SIZE_BITS + 3) : TOTAL_W;
	localparam logic [WW-1:0] WSUM_MAX  = WW'((64'd1 << WSUM_W) - 64'd1);
	localparam logic [WW-1:0] WASTE_MAX = WW'((64'd1 << WASTE_W) - 64'd1);
	localparam logic [WW-1:0] TOT_MAX_W = WW'((64'd1 << TOTAL_W) - 64'd1);
	localparam logic [EW-1:0] TOT_MAX_E = EW'((64'd1 << TOTAL_W) - 64'd1);

	logic [SIZE_BITS-1:0]  job;
	logic [PARTITIONS-1:0] fit;
	logic                  any_fit;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	logic [SIZE_BITS-1:0]  pick_size;
	logic                  rel_hit;
	logic [SIZE_BITS-1:0]  rel_size;
	logic [SIZE_BITS-1:0]  rel_held;
	logic [SIZE_BITS-1:0]  waste_v;
	logic [WW-1:0]         waste_w;
	logic [WW-1:0]         wsum_w;
	logic [WW-1:0]         wsum_new;
	logic [EW-1:0]         free_sum;
	logic [STATUS_W-1:0]   status_v;
	logic [IDX_W-1:0]      index_v;
	logic [WASTE_W-1:0]    waste_out;
	logic [TOTAL_W-1:0]    itot_out;
	logic [TOTAL_W-1:0]    etot_out;

	assign job = SIZE_BITS'(item.job_size);

	always_comb begin
		for (int i = 0; i < PARTITIONS; i++) begin
			fit[i] = (size[i] != '0) && (size[i] >= job);
		end
	end

	assign any_fit = |fit;

	// Lowest-numbered free partition that fits wins.
	always_comb begin
		found     = 1'b0;
		pick      = '0;
		pick_size = '0;
		for (int i = PARTITIONS - 1; i >= 0; i--) begin
			if (fit[i] && !busy[i]) begin
				found     = 1'b1;
				pick      = IDX_W'(i);
				pick_size = size[i];
			end
		end
	end

	always_comb begin
		rel_hit  = 1'b0;
		rel_size = '0;
		rel_held = '0;
		for (int i = 0; i < PARTITIONS; i++) begin
			if (busy[i] && item.release_index == IDX_W'(i)) begin
				rel_hit  = 1'b1;
				rel_size = size[i];
				rel_held = held[i];
			end
		end
	end

	assign wsum_w = WW'(waste_sum);

	always_comb begin
		busy_next      = busy;
		held_next      = held;
		waste_sum_next = waste_sum;
		waste_v        = '0;
		wsum_new       = wsum_w;
		status_v       = ST_GRANTED;
		index_v        = '0;
		if (item.action == ACT_ALLOC) begin
			if (found) begin
				waste_v  = pick_size - job;
				wsum_new = wsum_w + WW'(waste_v);
				if (wsum_new > WSUM_MAX) begin
					wsum_new = WSUM_MAX;
				end
				for (int i = 0; i < PARTITIONS; i++) begin
					if (pick == IDX_W'(i)) begin
						busy_next[i] = 1'b1;
						held_next[i] = job;
					end
				end
				status_v = ST_GRANTED;
				index_v  = pick;
			end else if (any_fit) begin
				status_v = ST_WAIT;
			end else begin
				status_v = ST_NEVER_FITS;
			end
		end else begin
			if (rel_hit) begin
				// The size may have been rewritten while busy; floor the waste at zero.
				waste_v  = (rel_size > rel_held) ? (rel_size - rel_held) : '0;
				wsum_new = (wsum_w > WW'(waste_v)) ? (wsum_w - WW'(waste_v)) : '0;
				for (int i = 0; i < PARTITIONS; i++) begin
					if (item.release_index == IDX_W'(i)) begin
						busy_next[i] = 1'b0;
						held_next[i] = '0;
					end
				end
				status_v = ST_RELEASED;
				index_v  = item.release_index;
			end else begin
				status_v = ST_ALREADY_FREE;
			end
		end
		waste_sum_next = wsum_new[WSUM_W-1:0];
	end

	assign waste_w   = WW'(waste_v);
	assign waste_out = (waste_w > WASTE_MAX) ? '1 : waste_w[WASTE_W-1:0];
	assign itot_out  = (wsum_new > TOT_MAX_W) ? '1 : wsum_new[TOTAL_W-1:0];

	// Free total is taken over the state after this request.
	always_comb begin
		free_sum = '0;
		for (int i = 0; i < PARTITIONS; i++) begin
			if (!busy_next[i]) begin
				free_sum = free_sum + EW'(size[i]);
			end
		end
	end

	assign etot_out = (free_sum > TOT_MAX_E) ? '1 : free_sum[TOTAL_W-1:0];

	assign result = {status_v, index_v, waste_out, itot_out, etot_out};

endmodule

>>> design/first_fit_partition_allocator.sv
// Top level of the first-fit fixed-partition allocator: registers, handshake and config port.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the result side is not stalled; the fit compares,
// priority pick and free-size adder all settle between the input and result registers.
// A stalled result holds the result register; one more request may wait in the input register.
// Reset (arst_n low, asynchronous): sizes zero, all free, waste sum zero, both registers empty.
module first_fit_partition_allocator
	import ffpa_pkg::*;
#(
	parameter int PARTITIONS = DEF_PARTITIONS,
	parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // job_size[15:0], release_index[18:16], zero pad
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,  // granted_index, waste, internal_total,
	                                            // external_total, zero pad
	output logic [STATUS_W-1:0]  m_axis_tuser   // status
);

	// Partition state. Sizes come from the configuration port; held sizes are only read
	// for busy partitions, so they need no reset.
	logic [PARTITIONS-1:0][SIZE_BITS-1:0] size_q;
	logic [PARTITIONS-1:0]                busy_q;
	logic [PARTITIONS-1:0][SIZE_BITS-1:0] held_q;
	logic [WSUM_W-1:0]                    waste_sum_q;

	logic [PARTITIONS-1:0]                busy_next;
	logic [PARTITIONS-1:0][SIZE_BITS-1:0] held_next;
	logic [WSUM_W-1:0]                    waste_sum_next;

	item_t   item_s1;
	logic    vld_s1;
	result_t result;
	result_t res_q;
	logic    out_vld_q;
	logic    adv;

	// The result register can take a new value when it is empty or being drained.
	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else begin
			for (int i = 0; i < PARTITIONS; i++) begin
				if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
					size_q[i] <= SIZE_BITS'(cfg_data);
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action        <= s_axis_tuser;
			item_s1.job_size      <= s_axis_tdata[15:0];
			item_s1.release_index <= s_axis_tdata[18:16];
		end
	end

	ffpa_step #(
		.PARTITIONS (PARTITIONS),
		.SIZE_BITS  (SIZE_BITS)
	) u_step (
		.item           (item_s1),
		.size           (size_q),
		.busy           (busy_q),
		.held           (held_q),
		.waste_sum      (waste_sum_q),
		.busy_next      (busy_next),
		.held_next      (held_next),
		.waste_sum_next (waste_sum_next),
		.result         (result)
	);

	// The state commits at the same edge the result is registered, so the next
	// request in the input register already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			waste_sum_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (vld_s1 && adv) begin
				busy_q      <= busy_next;
				waste_sum_q <= waste_sum_next;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv) begin
			held_q <= held_next;
			res_q  <= result;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {7'b0, res_q.external_total, res_q.internal_total,
	                        res_q.waste, res_q.granted_index};

endmodule
